// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the transmit ring slot manager.
// Both sample on clk and are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge
`define TDR_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// Check that a consequence holds in the cycle of its antecedent
`define TDR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");

`endif

// ===== hw/rtl/tdr_pkg.sv =====
// ----------------------------------------------------------------------------
// tdr_pkg
// Types, codes and constants shared by the transmit ring slot manager.
// ----------------------------------------------------------------------------
`default_nettype none

package tdr_pkg;

  // Field widths fixed by the request and result formats
  localparam int SLOT_FIELD_W  = 9;
  localparam int CNT_FIELD_W   = 10;
  localparam int COOKIE_W      = 14;
  localparam int COOKIE_SLOT_W = 12;
  localparam int CID_W         = 2;
  localparam int STATUS_W      = 2;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 10;

  // Default ring storage depth
  localparam int MAX_SLOTS_DEF = 512;

  // Decoupling queues between front, back and result port
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Operation codes
  localparam logic OP_REQ = 1'b0;
  localparam logic OP_CPL = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RING_SLOTS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_LEVEL    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESTART_LEVEL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CONTROLLER_ID = 2'd3;

  // Configuration reset values
  localparam logic [CFG_DATA_W-1:0] RING_SLOTS_RST    = 10'd512;
  localparam logic [CFG_DATA_W-1:0] STOP_LEVEL_RST    = 10'd64;
  localparam logic [CFG_DATA_W-1:0] RESTART_LEVEL_RST = 10'd128;
  localparam logic [CID_W-1:0]      CID_RST           = 2'd0;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] ring_slots;
    logic [CFG_DATA_W-1:0] stop_level;
    logic [CFG_DATA_W-1:0] restart_level;
    logic [CID_W-1:0]      controller_id;
  } cfg_t;

  // Classified request held between front and back
  typedef struct packed {
    logic                    is_cpl;
    logic                    first;
    logic                    last;
    logic [SLOT_FIELD_W-1:0] slot;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [SLOT_FIELD_W-1:0] granted_slot;
    logic [COOKIE_W-1:0]     cookie;
    logic                    frame_start_flag;
    logic                    frame_end_flag;
    logic                    table_end_flag;
    logic                    kick_valid;
    logic [SLOT_FIELD_W-1:0] kick_slot;
    logic                    queue_stopped;
    logic [CNT_FIELD_W-1:0]  freed_count;
    logic [CNT_FIELD_W-1:0]  used_count;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tdr_front.sv =====
// ----------------------------------------------------------------------------
// tdr_front
// Accepts requests, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tdr_front (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               push,
  output logic                                    full,
  input  wire logic                               in_operation,
  input  wire logic                               in_first_fragment,
  input  wire logic                               in_last_fragment,
  input  wire logic [tdr_pkg::SLOT_FIELD_W-1:0]   in_completion_slot,
  input  wire logic                               init_busy,
  output tdr_pkg::cmd_t                           cmd,
  output logic                                    cmd_valid,
  input  wire logic                               cmd_pop
);

  tdr_pkg::cmd_t                   q_r [tdr_pkg::Q_DEPTH];
  tdr_pkg::cmd_t                   cmd_in;
  logic [tdr_pkg::Q_PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [tdr_pkg::Q_PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [tdr_pkg::Q_CNT_W-1:0]     count_r, count_nxt;
  logic                            accept;
  logic                            deq;

  // Classify the request: drop fields the operation does not use
  always_comb begin
    cmd_in.is_cpl = (in_operation == tdr_pkg::OP_CPL);
    cmd_in.first  = in_first_fragment & ~cmd_in.is_cpl;
    cmd_in.last   = in_last_fragment & ~cmd_in.is_cpl;
    cmd_in.slot   = cmd_in.is_cpl ? in_completion_slot : '0;
  end

  // Hold off requests while the queue is full or the ring is being cleared
  assign full      = (count_r == tdr_pkg::Q_CNT_W'(tdr_pkg::Q_DEPTH)) | init_busy;
  assign accept    = push & ~full;
  assign cmd_valid = (count_r != '0);
  assign deq       = cmd_pop & cmd_valid;
  assign cmd       = q_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (accept) begin
      wr_ptr_nxt = (wr_ptr_r == tdr_pkg::Q_PTR_W'(tdr_pkg::Q_DEPTH - 1)) ?
                   '0 : wr_ptr_r + tdr_pkg::Q_PTR_W'(1);
    end
    if (deq) begin
      rd_ptr_nxt = (rd_ptr_r == tdr_pkg::Q_PTR_W'(tdr_pkg::Q_DEPTH - 1)) ?
                   '0 : rd_ptr_r + tdr_pkg::Q_PTR_W'(1);
    end
    if (accept && !deq) begin
      count_nxt = count_r + tdr_pkg::Q_CNT_W'(1);
    end else if (deq && !accept) begin
      count_nxt = count_r - tdr_pkg::Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the classified request
  always_ff @(posedge clk) begin
    if (accept) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tdr_back.sv =====
// ----------------------------------------------------------------------------
// tdr_back
// Carries out slot claims and frame completions against the slot table.
// ----------------------------------------------------------------------------
`default_nettype none

module tdr_back #(
  parameter int MAX_SLOTS = tdr_pkg::MAX_SLOTS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  tdr_pkg::cfg_t      cfg,
  input  tdr_pkg::cmd_t      cmd,
  input  wire logic          cmd_valid,
  output logic               cmd_pop,
  output tdr_pkg::res_t      res,
  output logic               res_push,
  input  wire logic          res_full,
  output logic               init_busy
);

  localparam int SW = $clog2(MAX_SLOTS);
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int KW = (CW > tdr_pkg::CNT_FIELD_W) ? CW : tdr_pkg::CNT_FIELD_W;

  localparam logic [1:0] S_INIT = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  // Slot table: bit 1 busy, bit 0 frame end
  logic [1:0]    mem [MAX_SLOTS];
  logic [1:0]    mem_rdata_r;
  logic          mem_we, mem_re;
  logic [SW-1:0] mem_waddr, mem_raddr;
  logic [1:0]    mem_wdata;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] slots_r, slots_nxt;
  logic [SW-1:0] last_r, last_nxt;
  logic          empty_r, empty_nxt;
  logic          susp_r, susp_nxt;
  logic [SW-1:0] first_r, first_nxt;
  logic [SW-1:0] cur_r, cur_nxt;
  logic [CW-1:0] freed_r, freed_nxt;
  logic [SW-1:0] init_r, init_nxt;

  logic [CW-1:0] ring_n;
  logic [SW-1:0] last_slot;
  logic [SW-1:0] claim_s;
  logic [CW-1:0] slots_inc, slots_dec, free_req, free_now, freed_inc;
  logic [SW-1:0] next_s;
  logic          slot_busy, slot_end;

  // Clamp the configured ring size to one and the table depth
  always_comb begin
    if (cfg.ring_slots == '0) begin
      ring_n = CW'(1);
    end else if (32'(cfg.ring_slots) > 32'(MAX_SLOTS)) begin
      ring_n = CW'(MAX_SLOTS);
    end else begin
      ring_n = CW'(cfg.ring_slots);
    end
  end

  assign last_slot = SW'(ring_n - CW'(1));
  assign claim_s   = (empty_r || last_r >= last_slot) ? '0 : last_r + SW'(1);
  assign slots_inc = slots_r + CW'(1);
  assign free_req  = ring_n - slots_inc;
  assign slots_dec = (slots_r != '0) ? slots_r - CW'(1) : '0;
  assign free_now  = (slots_r >= ring_n) ? '0 : ring_n - slots_r;
  assign freed_inc = freed_r + CW'(1);
  assign next_s    = (cur_r >= last_slot) ? '0 : cur_r + SW'(1);
  assign slot_busy = mem_rdata_r[1];
  assign slot_end  = mem_rdata_r[0];
  assign init_busy = (state_r == S_INIT);

  always_comb begin
    state_nxt = state_r;
    slots_nxt = slots_r;
    last_nxt  = last_r;
    empty_nxt = empty_r;
    susp_nxt  = susp_r;
    first_nxt = first_r;
    cur_nxt   = cur_r;
    freed_nxt = freed_r;
    init_nxt  = init_r;
    mem_we    = 1'b0;
    mem_waddr = cur_r;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = cur_r;
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    res       = '0;
    res.used_count    = tdr_pkg::CNT_FIELD_W'(slots_r);
    res.queue_stopped = susp_r;

    case (state_r)
      // Sweep the slot table clear after reset
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = init_r;
        if (init_r == SW'(MAX_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          init_nxt = init_r + SW'(1);
        end
      end

      // Take a request only when its result has room
      S_IDLE: begin
        if (cmd_valid && !res_full) begin
          cmd_pop = 1'b1;
          if (!cmd.is_cpl) begin
            if (slots_r >= ring_n) begin
              res_push   = 1'b1;
              res.status = tdr_pkg::ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = claim_s;
              mem_wdata = {1'b1, cmd.last};
              last_nxt  = claim_s;
              empty_nxt = 1'b0;
              slots_nxt = slots_inc;
              if (!susp_r && KW'(free_req) < KW'(cfg.stop_level)) begin
                susp_nxt = 1'b1;
              end
              if (cmd.first) begin
                first_nxt = claim_s;
              end
              res_push             = 1'b1;
              res.status           = tdr_pkg::ST_OK;
              res.granted_slot     = tdr_pkg::SLOT_FIELD_W'(claim_s);
              res.cookie           = {cfg.controller_id,
                                      tdr_pkg::COOKIE_SLOT_W'(claim_s)};
              res.frame_start_flag = cmd.first;
              res.frame_end_flag   = cmd.last;
              res.table_end_flag   = (claim_s == last_slot);
              if (cmd.last) begin
                res.kick_valid = 1'b1;
                res.kick_slot  = tdr_pkg::SLOT_FIELD_W'(cmd.first ? claim_s : first_r);
              end
              res.used_count    = tdr_pkg::CNT_FIELD_W'(slots_inc);
              res.queue_stopped = susp_nxt;
            end
          end else if (KW'(cmd.slot) >= KW'(ring_n)) begin
            res_push   = 1'b1;
            res.status = tdr_pkg::ST_BAD;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = SW'(cmd.slot);
            cur_nxt   = SW'(cmd.slot);
            freed_nxt = '0;
            state_nxt = S_WALK;
          end
        end
      end

      // Free one slot a cycle until the frame end mark, a free slot or one full lap
      S_WALK: begin
        if (!slot_busy) begin
          if (freed_r == '0) begin
            res_push   = 1'b1;
            res.status = tdr_pkg::ST_BAD;
            state_nxt  = S_IDLE;
          end else begin
            state_nxt = S_FIN;
          end
        end else begin
          mem_we    = 1'b1;
          mem_waddr = cur_r;
          slots_nxt = slots_dec;
          if (slots_dec == '0) begin
            empty_nxt = 1'b1;
          end
          freed_nxt = freed_inc;
          if (slot_end || freed_inc >= ring_n) begin
            state_nxt = S_FIN;
          end else begin
            cur_nxt   = next_s;
            mem_re    = 1'b1;
            mem_raddr = next_s;
          end
        end
      end

      // Resume the queue and report the completion
      S_FIN: begin
        if (susp_r && KW'(free_now) >= KW'(cfg.restart_level)) begin
          susp_nxt = 1'b0;
        end
        res_push          = 1'b1;
        res.status        = tdr_pkg::ST_OK;
        res.freed_count   = tdr_pkg::CNT_FIELD_W'(freed_r);
        res.queue_stopped = susp_nxt;
        state_nxt         = S_IDLE;
      end

      default: begin
        state_nxt = S_INIT;
        init_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      slots_r <= '0;
      last_r  <= '0;
      empty_r <= 1'b1;
      susp_r  <= 1'b0;
      first_r <= '0;
      cur_r   <= '0;
      freed_r <= '0;
      init_r  <= '0;
    end else begin
      state_r <= state_nxt;
      slots_r <= slots_nxt;
      last_r  <= last_nxt;
      empty_r <= empty_nxt;
      susp_r  <= susp_nxt;
      first_r <= first_nxt;
      cur_r   <= cur_nxt;
      freed_r <= freed_nxt;
      init_r  <= init_nxt;
    end
  end

  // Slot table port: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[mem_raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tdr_outq.sv =====
// ----------------------------------------------------------------------------
// tdr_outq
// Result queue that parts the back end from the result port.
// ----------------------------------------------------------------------------
`default_nettype none

module tdr_outq (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  tdr_pkg::res_t    wr_data,
  input  wire logic        wr_en,
  output logic             q_full,
  output tdr_pkg::res_t    rd_data,
  output logic             q_empty,
  input  wire logic        rd_en
);

  tdr_pkg::res_t                 q_r [tdr_pkg::Q_DEPTH];
  logic [tdr_pkg::Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [tdr_pkg::Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [tdr_pkg::Q_CNT_W-1:0]   count_r, count_nxt;
  logic                          enq, deq;

  assign q_full  = (count_r == tdr_pkg::Q_CNT_W'(tdr_pkg::Q_DEPTH));
  assign q_empty = (count_r == '0);
  assign enq     = wr_en & ~q_full;
  assign deq     = rd_en & ~q_empty;
  assign rd_data = q_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (enq) begin
      wr_ptr_nxt = (wr_ptr_r == tdr_pkg::Q_PTR_W'(tdr_pkg::Q_DEPTH - 1)) ?
                   '0 : wr_ptr_r + tdr_pkg::Q_PTR_W'(1);
    end
    if (deq) begin
      rd_ptr_nxt = (rd_ptr_r == tdr_pkg::Q_PTR_W'(tdr_pkg::Q_DEPTH - 1)) ?
                   '0 : rd_ptr_r + tdr_pkg::Q_PTR_W'(1);
    end
    if (enq && !deq) begin
      count_nxt = count_r + tdr_pkg::Q_CNT_W'(1);
    end else if (deq && !enq) begin
      count_nxt = count_r - tdr_pkg::Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the result
  always_ff @(posedge clk) begin
    if (enq) begin
      q_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tx_descriptor_ring_slot_manager_top.sv =====
// ----------------------------------------------------------------------------
// tx_descriptor_ring_slot_manager_top: transmit descriptor ring slot manager
// Claims, refusals, out-of-ring completions: registered in the front queue, then in the
// result queue; one per cycle while the result queue has room. Completion: the named
// slot is read, the walk frees slots in turn and S_FIN reports; a free first slot is refused.
// Reset: table clear pass over all MAX_SLOTS entries, full held high meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tx_descriptor_ring_slot_manager_top #(
  parameter int MAX_SLOTS = tdr_pkg::MAX_SLOTS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // request channel
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic                              in_operation,
  input  wire logic                              in_first_fragment,
  input  wire logic                              in_last_fragment,
  input  wire logic [tdr_pkg::SLOT_FIELD_W-1:0]  in_completion_slot,
  // result channel
  output logic                                   empty,
  input  wire logic                              pop,
  output logic [tdr_pkg::STATUS_W-1:0]           out_status,
  output logic [tdr_pkg::SLOT_FIELD_W-1:0]       out_granted_slot,
  output logic [tdr_pkg::COOKIE_W-1:0]           out_cookie,
  output logic                                   out_frame_start_flag,
  output logic                                   out_frame_end_flag,
  output logic                                   out_table_end_flag,
  output logic                                   out_kick_valid,
  output logic [tdr_pkg::SLOT_FIELD_W-1:0]       out_kick_slot,
  output logic                                   out_queue_stopped,
  output logic [tdr_pkg::CNT_FIELD_W-1:0]        out_freed_count,
  output logic [tdr_pkg::CNT_FIELD_W-1:0]        out_used_count,
  // configuration
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [tdr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tdr_pkg::CFG_DATA_W-1:0]    cfg_data
);

  tdr_pkg::cfg_t  cfg_r;
  tdr_pkg::cmd_t  cmd;
  tdr_pkg::res_t  res, res_head;
  logic           cmd_valid, cmd_pop;
  logic           res_push, res_full;
  logic           init_busy;

  // Register writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ring_slots    <= tdr_pkg::RING_SLOTS_RST;
      cfg_r.stop_level    <= tdr_pkg::STOP_LEVEL_RST;
      cfg_r.restart_level <= tdr_pkg::RESTART_LEVEL_RST;
      cfg_r.controller_id <= tdr_pkg::CID_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tdr_pkg::REG_RING_SLOTS:    cfg_r.ring_slots    <= cfg_data;
        tdr_pkg::REG_STOP_LEVEL:    cfg_r.stop_level    <= cfg_data;
        tdr_pkg::REG_RESTART_LEVEL: cfg_r.restart_level <= cfg_data;
        tdr_pkg::REG_CONTROLLER_ID: cfg_r.controller_id <= cfg_data[tdr_pkg::CID_W-1:0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  tdr_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_operation       (in_operation),
    .in_first_fragment  (in_first_fragment),
    .in_last_fragment   (in_last_fragment),
    .in_completion_slot (in_completion_slot),
    .init_busy          (init_busy),
    .cmd                (cmd),
    .cmd_valid          (cmd_valid),
    .cmd_pop            (cmd_pop)
  );

  tdr_back #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .res       (res),
    .res_push  (res_push),
    .res_full  (res_full),
    .init_busy (init_busy)
  );

  tdr_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_data (res),
    .wr_en   (res_push),
    .q_full  (res_full),
    .rd_data (res_head),
    .q_empty (empty),
    .rd_en   (pop)
  );

  assign out_status           = res_head.status;
  assign out_granted_slot     = res_head.granted_slot;
  assign out_cookie           = res_head.cookie;
  assign out_frame_start_flag = res_head.frame_start_flag;
  assign out_frame_end_flag   = res_head.frame_end_flag;
  assign out_table_end_flag   = res_head.table_end_flag;
  assign out_kick_valid       = res_head.kick_valid;
  assign out_kick_slot        = res_head.kick_slot;
  assign out_queue_stopped    = res_head.queue_stopped;
  assign out_freed_count      = res_head.freed_count;
  assign out_used_count       = res_head.used_count;

  // A result is never produced without room in the result queue
  `TDR_ASSERT_IMP(a_push_room, res_push, !res_full)
  // No request reaches the back end during the clearing pass
  `TDR_ASSERT_IMP(a_no_cmd_init, init_busy, !cmd_pop)
  // Slots are only freed by a successful completion
  `TDR_ASSERT_IMP(a_freed_ok, !empty && out_freed_count != '0, out_status == tdr_pkg::ST_OK)
  // A kick is only raised on a frame's last fragment
  `TDR_ASSERT_IMP(a_kick_end, !empty && out_kick_valid, out_frame_end_flag)

endmodule

`default_nettype wire

// ===== tb/tx_descriptor_ring_slot_manager_top_test.sv =====
// ----------------------------------------------------------------------------
// tx_descriptor_ring_slot_manager_top_test: slot manager self-checking bench
// Drives slot claims and frame completions into the ring through the push
// side, under a series of ring sizes, queue marks and controller ids. A
// scoreboard predicts every result from its own copy of the ring state, and
// each popped result is checked against it, field by field and in order.
// ----------------------------------------------------------------------------
module tx_descriptor_ring_slot_manager_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tdr_pkg::*;

  localparam int unsigned RING_DEPTH  = MAX_SLOTS_DEF;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned PHASE_ITEMS = 55;
  localparam int unsigned PLAN_LEN    = 8;
  // ring slots, stop level, restart level, controller id for each random phase
  localparam int unsigned RING_PLAN [PLAN_LEN][4] = '{
    '{8, 3, 6, 1}, '{3, 0, 0, 0}, '{5, 5, 1, 3}, '{16, 4, 12, 2},
    '{37, 10, 20, 1}, '{1023, 512, 512, 3}, '{512, 500, 505, 0}, '{64, 16, 32, 2}
  };

  // Ring state prediction and in-order result checking
  class ring_scoreboard;
    bit [CFG_DATA_W-1:0] ring_slots, stop_level, restart_level;
    bit [CID_W-1:0]      controller_id;
    int unsigned         in_use;
    int unsigned         last_slot;
    bit                  ring_idle;
    bit                  busy [RING_DEPTH];
    bit                  frame_end [RING_DEPTH];
    bit                  stopped;
    int unsigned         frame_head;
    res_t                awaited [$];
    int unsigned         mismatches, checked, accepted, refused, rejected;

    function new();
      ring_slots    = RING_SLOTS_RST;
      stop_level    = STOP_LEVEL_RST;
      restart_level = RESTART_LEVEL_RST;
      controller_id = CID_RST;
      in_use        = 0;
      last_slot     = 0;
      ring_idle     = 1'b1;
      stopped       = 1'b0;
      frame_head    = 0;
      foreach (busy[i]) begin
        busy[i]      = 1'b0;
        frame_end[i] = 1'b0;
      end
      mismatches = 0;
      checked    = 0;
      accepted   = 0;
      refused    = 0;
      rejected   = 0;
    endfunction

    // Clamp the programmed size into 1 .. storage depth
    function int unsigned ring_size();
      if (ring_slots == 0) return 1;
      if (ring_slots > RING_DEPTH) return RING_DEPTH;
      return ring_slots;
    endfunction

    function int unsigned ring_free(int unsigned n);
      return (in_use >= n) ? 0 : n - in_use;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_RING_SLOTS:    ring_slots    = value;
        REG_STOP_LEVEL:    stop_level    = value;
        REG_RESTART_LEVEL: restart_level = value;
        REG_CONTROLLER_ID: controller_id = value[CID_W-1:0];
        default: ;
      endcase
    endfunction

    // Advance the ring by one accepted request and queue its result
    function res_t note_item(logic op, logic first, logic last,
                             logic [SLOT_FIELD_W-1:0] cslot);
      res_t        r;
      int unsigned n, s, walked;
      bit          done;
      n = ring_size();
      r = '0;
      accepted++;
      if (op == OP_REQ) begin
        if (in_use >= n) begin
          r.status = ST_FULL;
          refused++;
        end else begin
          // restart at slot 0 on an empty ring or past the ring end
          if (ring_idle || last_slot >= n - 1) s = 0;
          else s = last_slot + 1;
          last_slot    = s;
          ring_idle    = 1'b0;
          busy[s]      = 1'b1;
          frame_end[s] = last;
          in_use++;
          if (!stopped && ring_free(n) < stop_level) stopped = 1'b1;
          if (first) frame_head = s;
          r.status           = ST_OK;
          r.granted_slot     = SLOT_FIELD_W'(s);
          r.cookie           = {controller_id, COOKIE_SLOT_W'(s)};
          r.frame_start_flag = first;
          r.frame_end_flag   = last;
          r.table_end_flag   = (s == n - 1);
          if (last) begin
            r.kick_valid = 1'b1;
            r.kick_slot  = SLOT_FIELD_W'(frame_head);
          end
        end
      end else begin
        s = cslot;
        if (s >= n || !busy[s]) begin
          r.status = ST_BAD;
          rejected++;
        end else begin
          // free up to the frame end, a hole, or one full lap
          walked = 0;
          done   = 1'b0;
          while (!done && walked < n && busy[s]) begin
            done         = frame_end[s];
            busy[s]      = 1'b0;
            frame_end[s] = 1'b0;
            if (in_use > 0) in_use--;
            if (in_use == 0) ring_idle = 1'b1;
            walked++;
            if (!done) s = (s >= n - 1) ? 0 : s + 1;
          end
          if (stopped && ring_free(n) >= restart_level) stopped = 1'b0;
          r.freed_count = CNT_FIELD_W'(walked);
        end
      end
      r.queue_stopped = stopped;
      r.used_count    = CNT_FIELD_W'(in_use);
      awaited.push_back(r);
      return r;
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 40) $display("[%0t] ERROR %s", $time, msg);
    endtask

    task compare_field(string field, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report($sformatf("result %0d: %s is 0x%0h, expected 0x%0h", checked, field, got, want));
    endtask

    task check_result(res_t got);
      res_t want;
      checked++;
      if (awaited.size() == 0) begin
        report($sformatf("result %0d arrived with no request outstanding", checked));
      end else begin
        want = awaited.pop_front();
        compare_field("status", got.status, want.status);
        compare_field("granted_slot", got.granted_slot, want.granted_slot);
        compare_field("cookie", got.cookie, want.cookie);
        compare_field("frame_start_flag", got.frame_start_flag, want.frame_start_flag);
        compare_field("frame_end_flag", got.frame_end_flag, want.frame_end_flag);
        compare_field("table_end_flag", got.table_end_flag, want.table_end_flag);
        compare_field("kick_valid", got.kick_valid, want.kick_valid);
        compare_field("kick_slot", got.kick_slot, want.kick_slot);
        compare_field("queue_stopped", got.queue_stopped, want.queue_stopped);
        compare_field("freed_count", got.freed_count, want.freed_count);
        compare_field("used_count", got.used_count, want.used_count);
      end
    endtask
  endclass

  logic                    clk, rst_n;
  logic                    push, full;
  logic                    in_operation, in_first_fragment, in_last_fragment;
  logic [SLOT_FIELD_W-1:0] in_completion_slot;
  logic                    empty, pop;
  logic [STATUS_W-1:0]     out_status;
  logic [SLOT_FIELD_W-1:0] out_granted_slot;
  logic [COOKIE_W-1:0]     out_cookie;
  logic                    out_frame_start_flag, out_frame_end_flag, out_table_end_flag;
  logic                    out_kick_valid;
  logic [SLOT_FIELD_W-1:0] out_kick_slot;
  logic                    out_queue_stopped;
  logic [CNT_FIELD_W-1:0]  out_freed_count, out_used_count;
  logic                    cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  ring_scoreboard          sb;
  res_t                    seen;
  bit                      calm;
  bit                      in_frame;
  int unsigned             cur_head;
  logic [SLOT_FIELD_W-1:0] open_heads [$];
  int unsigned             cycle_count;

  tx_descriptor_ring_slot_manager_top dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Present one request and hold it until the ring takes it
  task automatic send_item(input logic op, input logic first, input logic last,
                           input logic [SLOT_FIELD_W-1:0] slot);
    res_t want;
    int   k;
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    push               <= 1'b1;
    in_operation       <= op;
    in_first_fragment  <= first;
    in_last_fragment   <= last;
    in_completion_slot <= slot;
    @(posedge clk);
    while (full) @(posedge clk);
    want = sb.note_item(op, first, last, slot);
    // track open frames so later completions name real frame heads
    if (op == OP_REQ) begin
      if (want.status == ST_OK && first) begin
        in_frame = 1'b1;
        cur_head = want.granted_slot;
      end
      if (want.status == ST_OK && last) begin
        open_heads.push_back(want.kick_slot);
        in_frame = 1'b0;
      end
    end else begin
      for (k = open_heads.size() - 1; k >= 0; k--)
        if (open_heads[k] == slot) open_heads.delete(k);
      if (want.status == ST_OK && in_frame && cur_head == slot) in_frame = 1'b0;
    end
  endtask

  task automatic request(input logic first, input logic last);
    send_item(OP_REQ, first, last, SLOT_FIELD_W'($urandom));
  endtask

  task automatic complete(input int unsigned slot);
    send_item(OP_CPL, 1'($urandom), 1'($urandom), SLOT_FIELD_W'(slot));
  endtask

  // Drop push and wait until every outstanding result has been popped
  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_register(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input int unsigned ring, input int unsigned susp,
                           input int unsigned resm, input int unsigned cid);
    settle();
    write_reg(REG_RING_SLOTS, CFG_DATA_W'(ring));
    write_reg(REG_STOP_LEVEL, CFG_DATA_W'(susp));
    write_reg(REG_RESTART_LEVEL, CFG_DATA_W'(resm));
    // upper data bits are don't-care for the controller id
    write_reg(REG_CONTROLLER_ID, {(CFG_DATA_W - CID_W)'($urandom), CID_W'(cid)});
  endtask

  // Mostly well-formed frames and completions, with some raw noise
  task automatic random_item();
    int unsigned n, idx, roll;
    n    = sb.ring_size();
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      send_item(1'($urandom), 1'($urandom), 1'($urandom),
                ($urandom_range(0, 1) == 0) ? SLOT_FIELD_W'($urandom)
                                            : SLOT_FIELD_W'($urandom_range(0, n - 1)));
    end else if (sb.ring_free(n) == 0 && open_heads.size() == 0) begin
      // ring jammed by an unfinished frame: release it from its head
      complete(in_frame ? cur_head : $urandom_range(0, n - 1));
      in_frame = 1'b0;
    end else if (in_frame && sb.ring_free(n) > 0) begin
      request(1'b0, $urandom_range(0, 2) == 0);
    end else if (open_heads.size() != 0 && (sb.ring_free(n) < 2 || roll < 50)) begin
      idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, open_heads.size() - 1) : 0;
      complete(open_heads[idx]);
    end else begin
      request(1'b1, $urandom_range(0, 1) == 0);
    end
  endtask

  // Drain finished and unfinished frames before the ring is reprogrammed
  task automatic drain();
    if (in_frame) complete(cur_head);
    in_frame = 1'b0;
    while (open_heads.size() != 0) complete(open_heads[0]);
    settle();
  endtask

  // Check every popped result against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      seen.status           = out_status;
      seen.granted_slot     = out_granted_slot;
      seen.cookie           = out_cookie;
      seen.frame_start_flag = out_frame_start_flag;
      seen.frame_end_flag   = out_frame_end_flag;
      seen.table_end_flag   = out_table_end_flag;
      seen.kick_valid       = out_kick_valid;
      seen.kick_slot        = out_kick_slot;
      seen.queue_stopped    = out_queue_stopped;
      seen.freed_count      = out_freed_count;
      seen.used_count       = out_used_count;
      sb.check_result(seen);
    end
  end

  // Stall the result side in bursts, with quiet stretches in between
  initial begin
    int unsigned hold, quiet, roll;
    hold  = 0;
    quiet = 0;
    forever begin
      @(negedge clk);
      if (quiet != 0) begin
        quiet--;
      end else if (!calm && hold == 0) begin
        roll = $urandom_range(0, 39);
        if (roll < 3) hold = $urandom_range(1, 18);
        else if (roll == 3) quiet = $urandom_range(30, 120);
      end
      if (hold != 0) begin
        pop <= 1'b0;
        hold--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles", cycle_count);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int unsigned p;
    sb       = new();
    calm     = 1'b0;
    in_frame = 1'b0;
    cur_head = 0;
    rst_n              <= 1'b0;
    push               <= 1'b0;
    pop                <= 1'b0;
    in_operation       <= OP_REQ;
    in_first_fragment  <= 1'b0;
    in_last_fragment   <= 1'b0;
    in_completion_slot <= '0;
    cfg_valid          <= 1'b0;
    cfg_index          <= REG_RING_SLOTS;
    cfg_data           <= '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Default ring: frames, a stray last fragment, unknown and mid-frame completions
    request(1'b1, 1'b1);
    request(1'b1, 1'b0);
    request(1'b0, 1'b0);
    request(1'b0, 1'b1);
    request(1'b0, 1'b1);
    complete(511);
    complete(2);
    complete(1);
    complete(0);
    complete(4);

    // Zero size acts as a single slot; completion beyond the ring is refused
    configure(0, 0, 0, 3);
    request(1'b1, 1'b0);
    request(1'b1, 1'b1);
    complete(1);
    complete(0);

    // Fill a small ring with no frame end, then free it in one full lap
    configure(4, 3, 4, 2);
    repeat (4) request(1'b0, 1'b0);
    request(1'b1, 1'b1);
    complete(2);
    repeat (3) request(1'b1, 1'b1);
    complete(0);
    complete(1);

    // Shrink below the last claim, then below the used count
    settle();
    write_reg(REG_RING_SLOTS, CFG_DATA_W'(2));
    request(1'b1, 1'b1);
    complete(2);
    request(1'b1, 1'b1);
    settle();
    write_reg(REG_RING_SLOTS, CFG_DATA_W'(1));
    request(1'b0, 1'b1);
    complete(0);
    settle();
    write_reg(REG_RING_SLOTS, CFG_DATA_W'(4));
    complete(2);

    // Random phases over several ring settings; the last runs without stalls
    for (p = 0; p < PLAN_LEN; p++) begin
      if (p == PLAN_LEN - 1) calm = 1'b1;
      configure(RING_PLAN[p][0], RING_PLAN[p][1], RING_PLAN[p][2], RING_PLAN[p][3]);
      repeat (PHASE_ITEMS) random_item();
      drain();
    end

    repeat (RING_DEPTH + 16) @(posedge clk);
    $display("Covered %0d requests over %0d ring settings: %0d refused on a full ring,",
             sb.accepted, PLAN_LEN + 5, sb.refused);
    $display("%0d completions rejected, %0d results checked", sb.rejected, sb.checked);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
